FILE: rtl/llhs_pkg.sv
// Shared types and constants for the least-loaded host selector.
package llhs_pkg;

    localparam int NUM_HOSTS_DEF = 16;

    localparam int OP_W    = 3;
    localparam int HOST_W  = 4;
    localparam int DATA_W  = 64;
    localparam int MASK_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN  = 3'd0,
        OP_UPSERT = 3'd1,
        OP_END    = 3'd2,
        OP_ADD    = 3'd3,
        OP_SET    = 3'd4,
        OP_QMIN   = 3'd5,
        OP_QRUN   = 3'd6
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [HOST_W-1:0]        host;
        logic                     running;
        logic signed [DATA_W-1:0] correction;
        logic [DATA_W-1:0]        amount;
    } t_request;

    typedef struct packed {
        logic              found;
        logic [HOST_W-1:0] chosen_host;
        logic [DATA_W-1:0] chosen_load;
        logic [MASK_W-1:0] running_mask;
    } t_result;

    // Write enables into the counter/correction store
    typedef struct packed {
        logic cnt;
        logic corr;
    } t_mem_we;

endpackage

FILE: rtl/llhs_mem.sv
// Counter and correction store: two synchronous arrays, one write and one registered read port.
module llhs_mem
    import llhs_pkg::*;
#(
    parameter int DEPTH = NUM_HOSTS_DEF,
    parameter int AW    = $clog2(NUM_HOSTS_DEF)
) (
    input  logic              i_clk,
    input  t_mem_we           i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wcnt,
    input  logic [DATA_W-1:0] i_wcorr,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rcnt,
    output logic [DATA_W-1:0] o_rcorr
);

    logic [DATA_W-1:0] r_cnt_mem  [DEPTH];
    logic [DATA_W-1:0] r_corr_mem [DEPTH];
    logic [DATA_W-1:0] r_rcnt;
    logic [DATA_W-1:0] r_rcorr;

    always_ff @(posedge i_clk) begin
        if (i_we.cnt) begin
            r_cnt_mem[i_waddr] <= i_wcnt;
        end
        if (i_we.corr) begin
            r_corr_mem[i_waddr] <= i_wcorr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rcnt  <= r_cnt_mem[i_raddr];
        r_rcorr <= r_corr_mem[i_raddr];
    end

    assign o_rcnt  = r_rcnt;
    assign o_rcorr = r_rcorr;

endmodule

FILE: rtl/llhs_ctrl.sv
// Sequencer: host flags, request decode, read-modify-write and the minimum scan.
module llhs_ctrl
    import llhs_pkg::*;
#(
    parameter int NUM_HOSTS = NUM_HOSTS_DEF,
    parameter int AW        = $clog2(NUM_HOSTS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_request          i_req,
    output logic              o_busy,
    output logic              o_done,
    output t_result           o_result,
    output t_mem_we           o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [DATA_W-1:0] o_mem_wcnt,
    output logic [DATA_W-1:0] o_mem_wcorr,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [DATA_W-1:0] i_mem_rcnt,
    input  logic [DATA_W-1:0] i_mem_rcorr
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DRAIN = 5'b10000
    } t_state;

    localparam logic [6:0]    LP_N    = 7'(NUM_HOSTS);
    localparam logic [AW-1:0] LP_LAST = AW'(NUM_HOSTS - 1);

    t_state                 r_state, n_state;
    t_request               r_req, n_req;
    logic [NUM_HOSTS-1:0]   r_present, n_present;
    logic [NUM_HOSTS-1:0]   r_running, n_running;
    logic [NUM_HOSTS-1:0]   r_seen, n_seen;
    logic [AW-1:0]          r_idx, n_idx;
    logic                   r_done, n_done;
    t_result                r_result, n_result;

    // scan pipeline: p1 = memory data for an entry, p2 = its corrected load
    logic                   r_p1_act, r_p1_qual;
    logic [AW-1:0]          r_p1_idx;
    logic                   r_p2_act, r_p2_qual;
    logic [AW-1:0]          r_p2_idx;
    logic [DATA_W-1:0]      r_p2_sum;
    logic                   r_best_found;
    logic [AW-1:0]          r_best_idx;
    logic [DATA_W-1:0]      r_best_load;

    logic [AW-1:0]          w_haddr;
    logic                   w_valid;
    logic                   w_hit;
    logic [MASK_W-1:0]      w_mask;

    assign w_haddr = AW'(r_req.host);
    assign w_valid = 7'(r_req.host) < LP_N;
    assign w_hit   = w_valid && r_present[w_haddr];

    // running query: only the low 16 hosts are visible
    for (genvar gi = 0; gi < MASK_W; gi++) begin : g_mask
        if (gi < NUM_HOSTS) begin : g_on
            assign w_mask[gi] = r_present[gi] & r_running[gi];
        end else begin : g_off
            assign w_mask[gi] = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_present   = r_present;
        n_running   = r_running;
        n_seen      = r_seen;
        n_idx       = r_idx;
        n_done      = 1'b0;
        n_result    = r_result;
        o_mem_we    = '0;
        o_mem_waddr = w_haddr;
        o_mem_wcnt  = '0;
        o_mem_wcorr = $unsigned(r_req.correction);
        o_mem_raddr = w_haddr;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_result = '0;
                n_done   = 1'b1;
                n_state  = ST_IDLE;
                unique case (t_op'(r_req.operation))
                    OP_BEGIN: begin
                        n_seen = '0;
                    end
                    OP_UPSERT: begin
                        if (w_valid) begin
                            if (!r_present[w_haddr]) begin
                                n_present[w_haddr] = 1'b1;
                                o_mem_we.cnt       = 1'b1;
                                o_mem_we.corr      = 1'b1;
                            end
                            n_running[w_haddr] = r_req.running;
                            n_seen[w_haddr]    = 1'b1;
                        end
                    end
                    OP_END: begin
                        n_present = r_present & r_seen;
                        n_running = r_running & ~(r_present & ~r_seen);
                    end
                    OP_ADD: begin
                        // read now, write back the sum next cycle
                        if (w_hit) begin
                            n_done  = 1'b0;
                            n_state = ST_RMW;
                        end
                    end
                    OP_SET: begin
                        if (w_hit) begin
                            o_mem_we.cnt = 1'b1;
                            o_mem_wcnt   = r_req.amount;
                        end
                    end
                    OP_QMIN: begin
                        n_done  = 1'b0;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                    OP_QRUN: begin
                        n_result.running_mask = w_mask;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RMW: begin
                o_mem_we.cnt = 1'b1;
                o_mem_wcnt   = i_mem_rcnt + r_req.amount;
                n_result     = '0;
                n_done       = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SCAN: begin
                o_mem_raddr = r_idx;
                if (r_idx == LP_LAST) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_act && !r_p2_act) begin
                    n_result             = '0;
                    n_result.found       = r_best_found;
                    n_result.chosen_host = r_best_found ? HOST_W'(r_best_idx) : '0;
                    n_result.chosen_load = r_best_found ? r_best_load : '0;
                    n_done               = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_present <= '0;
            r_running <= '0;
            r_seen    <= '0;
            r_done    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_running <= n_running;
            r_seen    <= n_seen;
            r_done    <= n_done;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_result <= n_result;
    end

    // scan pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_act <= 1'b0;
            r_p2_act <= 1'b0;
        end else begin
            r_p1_act <= (r_state == ST_SCAN);
            r_p2_act <= r_p1_act;
        end
    end

    // scan pipeline data and running best
    always_ff @(posedge i_clk) begin
        r_p1_qual <= r_present[r_idx] & r_running[r_idx];
        r_p1_idx  <= r_idx;
        r_p2_qual <= r_p1_qual;
        r_p2_idx  <= r_p1_idx;
        r_p2_sum  <= i_mem_rcnt + i_mem_rcorr;
        if (r_state == ST_EXEC) begin
            r_best_found <= 1'b0;
            r_best_idx   <= '0;
            r_best_load  <= '1;
        end else if (r_p2_act && r_p2_qual && (r_p2_sum < r_best_load)) begin
            // strict compare keeps the lowest index on ties
            r_best_found <= 1'b1;
            r_best_idx   <= r_p2_idx;
            r_best_load  <= r_p2_sum;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/least_loaded_host_selector.sv
// Least-loaded host selector: top level joining the sequencer and the counter store.
// Add reads the counter, then writes back the sum; query min reads the store once per host
// and passes each entry through the p1 and p2 scan stages. One request is handled at a time,
// and the next is taken on the edge that ends the strobe cycle; the receiver never stalls a result.
// Synchronous active-low reset empties the host table; the counter store is not cleared.
module least_loaded_host_selector
    import llhs_pkg::*;
#(
    parameter int NUM_HOSTS = NUM_HOSTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_req,
    output logic     busy,
    output logic     o_done,
    output t_result  o_result
);

    localparam int AW = $clog2(NUM_HOSTS);

    // store access from the sequencer
    t_mem_we           w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [AW-1:0]     w_mem_raddr;
    logic [DATA_W-1:0] w_mem_wcnt;
    logic [DATA_W-1:0] w_mem_wcorr;
    logic [DATA_W-1:0] w_mem_rcnt;
    logic [DATA_W-1:0] w_mem_rcorr;

    // Flags live in the sequencer; counters and corrections in the store.
    // Add is a read-modify-write: busy holds off any overlapping access.
    llhs_ctrl #(
        .NUM_HOSTS (NUM_HOSTS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wcnt  (w_mem_wcnt),
        .o_mem_wcorr (w_mem_wcorr),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rcnt  (w_mem_rcnt),
        .i_mem_rcorr (w_mem_rcorr)
    );

    llhs_mem #(
        .DEPTH (NUM_HOSTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wcnt  (w_mem_wcnt),
        .i_wcorr (w_mem_wcorr),
        .i_raddr (w_mem_raddr),
        .o_rcnt  (w_mem_rcnt),
        .o_rcorr (w_mem_rcorr)
    );

endmodule

FILE: rtl/llhs_checker.sv
// Port-level checker for the least-loaded host selector, bound to the top level.
module llhs_checker
    import llhs_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input t_request i_req,
    input logic     busy,
    input logic     o_done,
    input t_result  o_result
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted request");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_qrun_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.operation == OP_QRUN) |-> ##2 o_done)
        else $error("running query result late");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.found |->
            (o_result.chosen_host == '0) && (o_result.chosen_load == '0))
        else $error("host or load set without a found host");

    a_found_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.found |-> (o_result.running_mask == '0))
        else $error("min result carries a running mask");

endmodule

bind least_loaded_host_selector llhs_checker u_llhs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_req    (i_req),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
